// ----- hw/rtl/baro_temp_press_compensation_core_defines.svh -----
// assertion macros shared by the compensation core checker
// no dependencies; the including module provides i_clk and i_rst_n
`ifndef BARO_TEMP_PRESS_COMPENSATION_CORE_DEFINES_SVH
`define BARO_TEMP_PRESS_COMPENSATION_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BTPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btpc check failed");

// next-cycle implication, disabled during reset
`define BTPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btpc check failed");

`endif

// ----- hw/rtl/btpc_pkg.sv -----
// shared types and constants of the barometric compensation pipeline
// no dependencies
package btpc_pkg;

    localparam int AdcW  = 20;
    localparam int QuoW  = 41;          // quotient bits, magnitude capped at 2^40
    localparam int RemW  = 85;          // numerator times 3125
    localparam int DuW   = 48;          // divisor magnitude
    localparam int CmpW  = RemW + 4;    // room for divisor shifted by QuoW

    localparam logic signed [26:0] TfOffset  = 27'sd128000;
    localparam logic [20:0]        AdcFull   = 21'd1048576;
    localparam logic [11:0]        DivScale  = 12'd3125;
    localparam logic signed [63:0] EOffset   = 64'sd140737488355328;
    localparam logic [QuoW-1:0]    QuoCap    = QuoW'(1) << (QuoW - 1);
    localparam logic signed [29:0] TempRound = 30'sd128;

    typedef enum logic [1:0] {
        CfgTemp   = 2'd0,
        CfgPressA = 2'd1,
        CfgPressB = 2'd2,
        CfgPressC = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_cal;

    typedef struct packed {
        logic               zero;
        logic               neg;
        logic               ovf;
        logic signed [15:0] temp;
        logic [RemW-1:0]    rem;
        logic [DuW-1:0]     du;
        logic [QuoW-1:0]    quo;
    } t_div_item;

endpackage

// ----- hw/rtl/btpc_temp.sv -----
// fine temperature pipeline, four register stages
// depends on btpc_pkg
module btpc_temp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_v,
    input  logic [19:0]            i_adc_t,
    input  logic [19:0]            i_adc_p,
    input  btpc_pkg::t_cal         i_cal,
    output logic                   o_v,
    output logic signed [25:0]     o_tf,
    output logic [19:0]            o_adc_p
);
    import btpc_pkg::*;

    logic [3:0] r_v;
    logic [19:0] r_ap [4];

    logic signed [18:0] r_d1, n_d1;
    logic signed [17:0] r_d2, n_d2;
    logic signed [34:0] r_m1, n_m1;
    logic signed [35:0] r_sq, n_sq;
    logic signed [23:0] r_v1, n_v1;
    logic signed [39:0] r_m3, n_m3;
    logic signed [25:0] r_tf, n_tf;
    logic signed [23:0] sqs;

    always_comb begin
        n_d1 = $signed({2'b00, i_adc_t[19:3]}) - $signed({2'b00, i_cal.t1, 1'b0});
        n_d2 = $signed({2'b00, i_adc_t[19:4]}) - $signed({2'b00, i_cal.t1});
        n_m1 = r_d1 * i_cal.t2;
        n_sq = r_d2 * r_d2;
        sqs  = 24'(r_sq >>> 12);
        n_v1 = 24'(r_m1 >>> 11);
        n_m3 = sqs * i_cal.t3;
        n_tf = 26'(r_v1) + 26'(r_m3 >>> 14);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1  <= n_d1;
            r_d2  <= n_d2;
            r_m1  <= n_m1;
            r_sq  <= n_sq;
            r_v1  <= n_v1;
            r_m3  <= n_m3;
            r_tf  <= n_tf;
            r_ap[0] <= i_adc_p;
            r_ap[1] <= r_ap[0];
            r_ap[2] <= r_ap[1];
            r_ap[3] <= r_ap[2];
        end
    end

    assign o_v     = r_v[3];
    assign o_tf    = r_tf;
    assign o_adc_p = r_ap[3];
endmodule

// ----- hw/rtl/btpc_pre.sv -----
// pressure numerator and divisor pipeline, seven register stages
// depends on btpc_pkg
module btpc_pre (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_v,
    input  logic signed [25:0]     i_tf,
    input  logic [19:0]            i_adc_p,
    input  btpc_pkg::t_cal         i_cal,
    output logic                   o_v,
    output btpc_pkg::t_div_item    o_item
);
    import btpc_pkg::*;

    logic [6:0] r_v;
    logic signed [15:0] r_temp [6];
    logic [19:0]        r_ap [4];

    logic signed [26:0] r1_a, n1_a;
    logic signed [15:0] n1_temp;
    logic signed [29:0] t5;
    logic signed [21:0] t21;
    logic signed [53:0] r2_aa, n2_aa;
    logic signed [42:0] r2_ap5, n2_ap5, r2_ap2, n2_ap2, r3_ap5, r3_ap2;
    logic signed [69:0] r3_aap6, n3_aap6, r3_aap3, n3_aap3;
    logic signed [71:0] r4_b, n4_b;
    logic signed [62:0] c;
    logic signed [63:0] r4_e, n4_e;
    logic signed [80:0] r5_ep1, n5_ep1;
    logic signed [72:0] r5_n, n5_n, nbase;
    logic [20:0]        nm;
    logic signed [47:0] dv;
    logic [72:0]        r6_nu, n6_nu;
    logic [DuW-1:0]     r6_du, n6_du;
    logic               r6_zero, n6_zero, r6_neg, n6_neg;
    t_div_item          r7_item, n7_item;

    always_comb begin
        // stage 1: offset fine temperature, rounded temperature
        n1_a = 27'(i_tf) - TfOffset;
        t5   = 30'(i_tf) * 30'sd5 + TempRound;
        t21  = 22'(t5 >>> 8);
        if (t21 > 22'sd32767) begin
            n1_temp = 16'sh7fff;
        end else if (t21 < -22'sd32768) begin
            n1_temp = -16'sd32768;
        end else begin
            n1_temp = 16'(t21);
        end
        // stage 2
        n2_aa  = r1_a * r1_a;
        n2_ap5 = r1_a * i_cal.p5;
        n2_ap2 = r1_a * i_cal.p2;
        // stage 3
        n3_aap6 = r2_aa * i_cal.p6;
        n3_aap3 = r2_aa * i_cal.p3;
        // stage 4
        n4_b = 72'(r3_aap6) + (72'(r3_ap5) <<< 17) + (72'(i_cal.p4) <<< 35);
        c    = 63'(r3_aap3 >>> 8) + (63'(r3_ap2) <<< 12);
        n4_e = EOffset + 64'(c);
        // stage 5
        n5_ep1 = r4_e * $signed({1'b0, i_cal.p1});
        nm     = AdcFull - 21'(r_ap[3]);
        nbase  = $signed({21'b0, nm, 31'b0});
        n5_n   = nbase - 73'(r4_b);
        // stage 6: magnitudes and sign
        dv      = 48'(r5_ep1 >>> 33);
        n6_nu   = r5_n[72] ? 73'(-r5_n) : 73'(r5_n);
        n6_du   = dv[47] ? DuW'(-dv) : DuW'(dv);
        n6_zero = (dv == '0);
        n6_neg  = r5_n[72] ^ dv[47];
        // stage 7: scaled numerator
        n7_item      = '0;
        n7_item.zero = r6_zero;
        n7_item.neg  = r6_neg;
        n7_item.temp = r_temp[5];
        n7_item.rem  = RemW'(r6_nu) * RemW'(DivScale);
        n7_item.du   = r6_du;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a    <= n1_a;
            r2_aa   <= n2_aa;
            r2_ap5  <= n2_ap5;
            r2_ap2  <= n2_ap2;
            r3_aap6 <= n3_aap6;
            r3_aap3 <= n3_aap3;
            r3_ap5  <= r2_ap5;
            r3_ap2  <= r2_ap2;
            r4_b    <= n4_b;
            r4_e    <= n4_e;
            r5_ep1  <= n5_ep1;
            r5_n    <= n5_n;
            r6_nu   <= n6_nu;
            r6_du   <= n6_du;
            r6_zero <= n6_zero;
            r6_neg  <= n6_neg;
            r7_item <= n7_item;
            r_temp[0] <= n1_temp;
            for (int i = 1; i < 6; i++) begin
                r_temp[i] <= r_temp[i-1];
            end
            r_ap[0] <= i_adc_p;
            for (int i = 1; i < 4; i++) begin
                r_ap[i] <= r_ap[i-1];
            end
        end
    end

    assign o_v    = r_v[6];
    assign o_item = r7_item;
endmodule

// ----- hw/rtl/btpc_div.sv -----
// pipelined restoring divider, one quotient bit per stage plus an overflow stage
// depends on btpc_pkg
module btpc_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_v,
    input  btpc_pkg::t_div_item    i_item,
    output logic                   o_v,
    output btpc_pkg::t_div_item    o_item
);
    import btpc_pkg::*;

    logic [QuoW:0] r_v;
    t_div_item     r_it [QuoW+1];
    t_div_item     n_it [QuoW+1];
    logic [CmpW-1:0] dsh;

    always_comb begin
        // entry: quotient would need more than QuoW bits
        n_it[0]     = i_item;
        n_it[0].quo = '0;
        n_it[0].ovf = CmpW'(i_item.rem) >= (CmpW'(i_item.du) << QuoW);
        dsh = '0;
        for (int i = 0; i < QuoW; i++) begin
            n_it[i+1] = r_it[i];
            dsh = CmpW'(r_it[i].du) << (QuoW - 1 - i);
            if (CmpW'(r_it[i].rem) >= dsh) begin
                n_it[i+1].rem = r_it[i].rem - dsh[RemW-1:0];
                n_it[i+1].quo[QuoW-1-i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QuoW-1:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i <= QuoW; i++) begin
                r_it[i] <= n_it[i];
            end
        end
    end

    assign o_v    = r_v[QuoW];
    assign o_item = r_it[QuoW];
endmodule

// ----- hw/rtl/btpc_post.sv -----
// pressure correction terms and output register, four register stages
// depends on btpc_pkg
module btpc_post (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_v,
    input  btpc_pkg::t_div_item    i_item,
    input  btpc_pkg::t_cal         i_cal,
    output logic                   o_v,
    output logic signed [15:0]     o_temp,
    output logic [23:0]            o_pa,
    output logic                   o_pv
);
    import btpc_pkg::*;

    logic [3:0]         r_v;
    logic signed [15:0] r_temp [4];
    logic [2:0]         r_zero;

    logic [QuoW-1:0]    m;
    logic signed [41:0] r1_q, n1_q, r2_q, r3_q;
    logic signed [28:0] s;
    logic signed [57:0] r2_x, n2_x, r2_p8q, n2_p8q;
    logic signed [73:0] r3_xp9, n3_xp9;
    logic signed [38:0] r3_w2, n3_w2;
    logic signed [48:0] w1;
    logic signed [49:0] sum;
    logic signed [42:0] r;
    logic signed [34:0] pa;
    logic [23:0]        n4_pa;

    always_comb begin
        // stage 1: capped, signed quotient
        if (i_item.ovf || (i_item.quo > QuoCap)) begin
            m = QuoCap;
        end else begin
            m = i_item.quo;
        end
        n1_q = i_item.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        // stage 2
        s      = 29'(r1_q >>> 13);
        n2_x   = s * s;
        n2_p8q = r1_q * i_cal.p8;
        // stage 3
        n3_xp9 = r2_x * i_cal.p9;
        n3_w2  = 39'(r2_p8q >>> 19);
        // stage 4
        w1  = 49'(r3_xp9 >>> 25);
        sum = 50'(r3_q) + 50'(w1) + 50'(r3_w2);
        r   = 43'(sum >>> 8) + (43'(i_cal.p7) <<< 4);
        pa  = 35'(r >>> 8);
        if (r_zero[2] || pa < 0) begin
            n4_pa = '0;
        end else if (pa > 35'sd16777215) begin
            n4_pa = 24'hffffff;
        end else begin
            n4_pa = 24'(pa);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_q   <= n1_q;
            r2_q   <= r1_q;
            r3_q   <= r2_q;
            r2_x   <= n2_x;
            r2_p8q <= n2_p8q;
            r3_xp9 <= n3_xp9;
            r3_w2  <= n3_w2;
            o_pa   <= n4_pa;
            o_pv   <= ~r_zero[2];
            r_zero <= {r_zero[1:0], i_item.zero};
            r_temp[0] <= i_item.temp;
            for (int i = 1; i < 4; i++) begin
                r_temp[i] <= r_temp[i-1];
            end
        end
    end

    assign o_v    = r_v[3];
    assign o_temp = r_temp[3];
endmodule

// ----- hw/rtl/baro_temp_press_compensation_core.sv -----
// throughput: one sample per cycle while the output register is empty or taken
// the 42-stage divider pipeline sets most of the depth
// the whole pipeline advances together when the output register is empty or taken
// reset (synchronous, active low) clears all stage valid bits and the calibration
// registers; the configuration port is always ready
module baro_temp_press_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,     // adc_temperature[19:0], adc_pressure[39:20]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,     // temp_centideg[15:0], pressure_pa[39:16]
    output logic [0:0]  o_m_tuser,     // pressure_valid[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import btpc_pkg::*;

    logic [47:0] r_cal_t;
    logic [63:0] r_cal_pa;
    logic [63:0] r_cal_pb;
    logic [15:0] r_cal_pc;
    t_cal        cal;

    logic               en;
    logic               t_v, p_v, d_v, o_v;
    logic signed [25:0] tf;
    logic [19:0]        ap;
    t_div_item          p_item, d_item;
    logic signed [15:0] temp;
    logic [23:0]        pa;
    logic               pv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t  <= '0;
            r_cal_pa <= '0;
            r_cal_pb <= '0;
            r_cal_pc <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CfgTemp:   r_cal_t  <= i_cfg_data[47:0];
                CfgPressA: r_cal_pa <= i_cfg_data;
                CfgPressB: r_cal_pb <= i_cfg_data;
                CfgPressC: r_cal_pc <= i_cfg_data[15:0];
                default:   r_cal_t  <= r_cal_t;
            endcase
        end
    end

    always_comb begin
        cal.t1 = r_cal_t[15:0];
        cal.t2 = $signed(r_cal_t[31:16]);
        cal.t3 = $signed(r_cal_t[47:32]);
        cal.p1 = r_cal_pa[15:0];
        cal.p2 = $signed(r_cal_pa[31:16]);
        cal.p3 = $signed(r_cal_pa[47:32]);
        cal.p4 = $signed(r_cal_pa[63:48]);
        cal.p5 = $signed(r_cal_pb[15:0]);
        cal.p6 = $signed(r_cal_pb[31:16]);
        cal.p7 = $signed(r_cal_pb[47:32]);
        cal.p8 = $signed(r_cal_pb[63:48]);
        cal.p9 = $signed(r_cal_pc);
    end

    // every stage moves when the output register can take a transfer
    assign en         = ~o_v | i_m_tready;
    assign o_s_tready = en;

    btpc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (i_s_tvalid),
        .i_adc_t (i_s_tdata[19:0]),
        .i_adc_p (i_s_tdata[39:20]),
        .i_cal   (cal),
        .o_v     (t_v),
        .o_tf    (tf),
        .o_adc_p (ap)
    );

    btpc_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (t_v),
        .i_tf    (tf),
        .i_adc_p (ap),
        .i_cal   (cal),
        .o_v     (p_v),
        .o_item  (p_item)
    );

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (p_v),
        .i_item  (p_item),
        .o_v     (d_v),
        .o_item  (d_item)
    );

    btpc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (d_v),
        .i_item  (d_item),
        .i_cal   (cal),
        .o_v     (o_v),
        .o_temp  (temp),
        .o_pa    (pa),
        .o_pv    (pv)
    );

    assign o_m_tvalid = o_v;
    assign o_m_tdata  = {pa, temp};
    assign o_m_tuser  = pv;
endmodule

// ----- hw/rtl/btpc_checker.sv -----
// port-level checks for the compensation core, bound to the top level
// depends on baro_temp_press_compensation_core_defines.svh
`include "baro_temp_press_compensation_core_defines.svh"

module btpc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_s_tready,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] o_m_tdata,
    input  logic [0:0]  o_m_tuser
);
    // a stalled result holds
    `BTPC_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // zero divisor forces pressure to zero
    `BTPC_ASSERT_IMP(a_zero_pa, o_m_tvalid && !o_m_tuser[0], o_m_tdata[39:16] == 24'd0)

    // with nothing waiting at the output the input side must take transfers
    `BTPC_ASSERT_IMP(a_ready_free, !o_m_tvalid || i_m_tready, o_s_tready)
endmodule

bind baro_temp_press_compensation_core btpc_checker u_btpc_checker (.*);

// ----- dv/tb_baro_temp_press_compensation_core.sv -----
// self-checking testbench for baro_temp_press_compensation_core
// depends on btpc_pkg and the core rtl; has its own integer compensation predictor
module tb_baro_temp_press_compensation_core;
    import btpc_pkg::*;

    localparam int WatchdogLimit = 4000;
    localparam int Drain         = 80;     // more than the core's input-to-output latency

    typedef struct {
        logic signed [15:0] temp_x100;
        logic [23:0]        press_pa;
        logic               press_ok;
    } t_reading;

    class compensation_sb;
        logic [47:0] cal_t;
        logic [63:0] cal_a;
        logic [63:0] cal_b;
        logic [15:0] cal_c;
        t_reading    readings[$];
        int          n_bad;
        int          n_good;
        int          n_invalid;

        function new();
            cal_t = '0; cal_a = '0; cal_b = '0; cal_c = '0;
            n_bad = 0; n_good = 0; n_invalid = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [63:0] v);
            case (idx)
                CfgTemp:   cal_t = v[47:0];
                CfgPressA: cal_a = v;
                CfgPressB: cal_b = v;
                CfgPressC: cal_c = v[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return readings.size();
        endfunction

        // integer compensation worked at 128 bits so nothing wraps
        function void note(logic [19:0] adc_t, logic [19:0] adc_p);
            logic signed [127:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [127:0] at, ap, d, v1, v2, tf, tc, a, b, c, e, dv, n, q;
            logic signed [127:0] s, x, w1, w2, r, pa;
            logic [127:0]        nu, du, qa, rb, m, cap;
            t_reading            rd;
            at = {108'd0, adc_t};
            ap = {108'd0, adc_p};
            t1 = {112'd0, cal_t[15:0]};
            t2 = $signed(cal_t[31:16]);
            t3 = $signed(cal_t[47:32]);
            p1 = {112'd0, cal_a[15:0]};
            p2 = $signed(cal_a[31:16]);
            p3 = $signed(cal_a[47:32]);
            p4 = $signed(cal_a[63:48]);
            p5 = $signed(cal_b[15:0]);
            p6 = $signed(cal_b[31:16]);
            p7 = $signed(cal_b[47:32]);
            p8 = $signed(cal_b[63:48]);
            p9 = $signed(cal_c);
            cap = 128'd1 << 40;

            d  = (at >>> 3) - 2 * t1;
            v1 = (d * t2) >>> 11;
            d  = (at >>> 4) - t1;
            v2 = (((d * d) >>> 12) * t3) >>> 14;
            tf = v1 + v2;
            tc = (tf * 5 + 128) >>> 8;
            if (tc > 32767) tc = 32767;
            if (tc < -32768) tc = -32768;
            rd.temp_x100 = tc[15:0];

            a  = tf - 128000;
            b  = a * a * p6 + a * p5 * (128'sd1 <<< 17) + p4 * (128'sd1 <<< 35);
            c  = ((a * a * p3) >>> 8) + a * p2 * 4096;
            e  = (128'sd1 <<< 47) + c;
            dv = (e * p1) >>> 33;

            if (dv == 0) begin
                rd.press_ok = 1'b0;
                pa = 0;
            end else begin
                rd.press_ok = 1'b1;
                n  = (1048576 - ap) * (128'sd1 <<< 31) - b;
                nu = (n < 0) ? -n : n;
                du = (dv < 0) ? -dv : dv;
                qa = nu / du;
                rb = nu % du;
                if (qa > cap / 3125) begin
                    m = cap;
                end else begin
                    m = qa * 3125 + (rb * 3125) / du;
                    if (m > cap) m = cap;
                end
                q  = ((n < 0) != (dv < 0)) ? -$signed(m) : $signed(m);
                s  = q >>> 13;
                x  = s * s;
                w1 = (x * p9) >>> 25;
                w2 = (p8 * q) >>> 19;
                r  = ((q + w1 + w2) >>> 8) + p7 * 16;
                pa = r >>> 8;
                if (pa < 0) pa = 0;
                if (pa > 24'hFFFFFF) pa = 24'hFFFFFF;
            end
            rd.press_pa = pa[23:0];
            readings.push_back(rd);
        endfunction

        function void check(logic signed [15:0] t, logic [23:0] p, logic ok);
            t_reading w;
            if (readings.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result transfer: temp %0d press %0d ok %0b", t, p, ok);
                return;
            end
            w = readings.pop_front();
            if (w.temp_x100 !== t || w.press_pa !== p || w.press_ok !== ok) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch: temp %0d/%0d press %0d/%0d ok %0b/%0b (exp/act)",
                             w.temp_x100, t, w.press_pa, p, w.press_ok, ok);
            end else begin
                n_good++;
                if (!ok) n_invalid++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    compensation_sb sb = new();
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;
    int n_sent = 0;

    baro_temp_press_compensation_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: check each transfer, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check(o_m_tdata[15:0], o_m_tdata[39:16], o_m_tuser[0]);
        i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
            $display("baro_temp_press_compensation_core test failed");
            $finish;
        end
    end

    task automatic send_sample(logic [19:0] adc_t, logic [19:0] adc_p);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {adc_p, adc_t};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note(adc_t, adc_p);
        n_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic load_cal(logic [47:0] ct, logic [63:0] ca, logic [63:0] cb,
                            logic [15:0] cc);
        t_cfg_idx    idx;
        logic [63:0] v;
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_idx'(k);
            case (idx)
                CfgTemp:   v = {16'd0, ct};
                CfgPressA: v = ca;
                CfgPressB: v = cb;
                default:   v = {48'd0, cc};
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= v;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(idx, v);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_samples(int count);
        logic [19:0] at;
        logic [19:0] ap;
        for (int k = 0; k < count; k++) begin
            case ((k / 35) % 4)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 46; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 46; end
                default: begin tx_gap_pct = 29; rx_stall_pct = 29; end
            endcase
            if (k == count / 2) wait_drained();
            if ($urandom_range(1)) begin
                at = 20'($urandom_range(620000, 380000));
                ap = 20'($urandom_range(520000, 220000));
            end else begin
                at = 20'($urandom);
                ap = 20'($urandom);
            end
            send_sample(at, ap);
        end
    endtask

    initial begin
        logic [47:0] ct;
        logic [63:0] ca;
        logic [63:0] cb;
        logic [15:0] cc;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero calibration gives a zero divisor: pressure flagged invalid
        load_cal('0, '0, '0, '0);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'd519888, 20'd415148);

        for (int setting = 0; setting < 6; setting++) begin
            case (setting)
                0: begin    // typical sensor trim
                    ct = {16'hFC18, 16'd26435, 16'd27504};
                    ca = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
                    cb = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
                    cc = 16'd6000;
                end
                1: begin    // tiny divisor drives the quotient into its cap
                    ct = {16'd0, 16'd26435, 16'd27504};
                    ca = {48'd0, 16'd1};
                    cb = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
                    cc = 16'h7FFF;
                end
                2: begin
                    ct = '1; ca = '1; cb = '1; cc = '1;
                end
                3: begin    // largest t and p1-p4 coefficients, most negative p5-p9
                    ct = {16'h7FFF, 16'h7FFF, 16'hFFFF};
                    ca = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
                    cb = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
                    cc = 16'h8000;
                end
                default: begin
                    ct = 48'({$urandom, $urandom});
                    ca = {$urandom, $urandom};
                    cb = {$urandom, $urandom};
                    cc = 16'($urandom);
                end
            endcase
            wait_drained();
            repeat (Drain) @(posedge i_clk);
            load_cal(ct, ca, cb, cc);
            tx_gap_pct = 0;
            rx_stall_pct = 0;
            send_sample(20'd0, 20'd0);
            send_sample(20'hFFFFF, 20'd0);
            send_sample(20'd0, 20'hFFFFF);
            send_sample(20'hFFFFF, 20'hFFFFF);
            send_sample(20'd519888, 20'd415148);
            random_samples(140);
        end

        wait_drained();
        repeat (Drain) @(posedge i_clk);
        $display("covered %0d samples over seven calibration sets with mixed gaps and stalls",
                 n_sent);
        $display("%0d results matched, %0d with pressure flagged invalid, %0d errors",
                 sb.n_good, sb.n_invalid, sb.n_bad);
        if (sb.n_bad == 0 && sb.pending() == 0)
            $display("baro_temp_press_compensation_core test passed");
        else
            $display("baro_temp_press_compensation_core test failed");
        $finish;
    end

endmodule
